// ===== sv/mexp_pkg.sv =====
// Shared constants for the modular exponentiation block.
// No dependencies; imported by every module of the block.
package mexp_pkg;

  // Default operand width and the allowed range of the width parameter.
  localparam int MEXP_WIDTH     = 32;
  localparam int MEXP_WIDTH_MIN = 2;
  localparam int MEXP_WIDTH_MAX = 64;

  // Register index of the modulus on the configuration port.
  localparam int REG_MODULUS = 0;

  // Round a bit count up to whole bytes.
  function automatic int byte_bits(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

// ===== sv/mexp_addmod.sv =====
// Modular adder: (x + y) mod m for x, y below m.
// Depends on mexp_pkg for the default width.
module mexp_addmod import mexp_pkg::*; #(
  parameter int WIDTH = MEXP_WIDTH
) (
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  input  logic [WIDTH-1:0] m,
  output logic [WIDTH-1:0] sum
);

  logic [WIDTH:0] raw;
  logic [WIDTH:0] reduced;

  // The carry bit keeps the sum exact, so one compare against m decides.
  always_comb begin
    raw     = {1'b0, x} + {1'b0, y};
    reduced = raw - {1'b0, m};
    if (raw >= {1'b0, m}) begin
      sum = reduced[WIDTH-1:0];
    end else begin
      sum = raw[WIDTH-1:0];
    end
  end

endmodule

// ===== sv/mexp_modmul.sv =====
// Shift-and-add modular multiplier: a * b mod m, a below m, b any value.
// Depends on mexp_pkg and mexp_addmod; one doubling and one add step per bit of b.
module mexp_modmul import mexp_pkg::*; #(
  parameter int WIDTH = MEXP_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH-1:0] m,
  output logic             busy,
  output logic             done,
  output logic [WIDTH-1:0] product
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef enum logic [1:0] {
    MM_IDLE,
    MM_DBL,
    MM_ADD
  } mm_state_t;

  mm_state_t        state;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] mcand;
  logic [WIDTH-1:0] mplier;
  logic [WIDTH-1:0] modulus;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] addend;
  logic [WIDTH-1:0] sum;

  // The single adder either doubles the accumulator or adds the multiplicand.
  assign addend = (state == MM_DBL) ? acc : mcand;

  mexp_addmod #(.WIDTH(WIDTH)) u_addmod (
    .x   (acc),
    .y   (addend),
    .m   (modulus),
    .sum (sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MM_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == MM_ADD) && (cnt == '0);
      unique case (state)
        MM_IDLE: begin
          if (start) begin
            acc     <= '0;
            mcand   <= a;
            mplier  <= b;
            modulus <= m;
            cnt     <= CNT_W'(WIDTH - 1);
            state   <= MM_DBL;
          end
        end
        MM_DBL: begin
          acc   <= sum;
          state <= MM_ADD;
        end
        MM_ADD: begin
          if (mplier[WIDTH-1]) begin
            acc <= sum;
          end
          mplier <= mplier << 1;
          if (cnt == '0) begin
            state <= MM_IDLE;
          end else begin
            cnt   <= cnt - 1'b1;
            state <= MM_DBL;
          end
        end
        default: state <= MM_IDLE;
      endcase
    end
  end

  assign busy    = (state != MM_IDLE);
  assign product = acc;

endmodule

// ===== sv/modular_exponentiation.sv =====
// Modular exponentiation: power_mod = base ** exponent mod modulus.
// The input channel (s_tvalid, s_tready, s_tdata) carries base in the low WIDTH
// bits of s_tdata and exponent above it. The output channel (m_tvalid, m_tready,
// m_tdata) carries one result per input transaction, in order.
// The modulus is written over the APB port at byte address 0 (reset value 1);
// a write of zero is ignored. Write it only while the block is idle.
// An exponent of zero gives 1 without any arithmetic.
// Otherwise every one of the WIDTH exponent bits costs a modular squaring plus,
// for a set bit, a modular multiply by the base. Each modular product runs on
// one shared shift-and-add multiplier that takes a doubling step and an add
// step per bit of its second operand. The next item is accepted only once the
// result of the last one has moved to the output register.
// s_tready is high only while no item is in progress. A finished result sits in
// the output register until taken; the next item may be accepted meanwhile, but
// its result waits for that register to drain.
// Reset (rst, synchronous) clears the sequencer and the output valid and sets
// the modulus to 1.
module modular_exponentiation import mexp_pkg::*; #(
  parameter int WIDTH = MEXP_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // s_tdata fields from bit 0: base, exponent
  input  logic [byte_bits(2*WIDTH)-1:0]         s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // m_tdata fields from bit 0: power_mod
  output logic [byte_bits(WIDTH)-1:0]           m_tdata,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [((WIDTH > 32) ? 3 : 2):0]       paddr,
  input  logic [((WIDTH > 32) ? 64 : 32)-1:0]   pwdata,
  output logic [((WIDTH > 32) ? 64 : 32)-1:0]   prdata,
  output logic                                  pready
);

  localparam int REG_SHIFT = (WIDTH > 32) ? 3 : 2;
  localparam int ADDR_W    = REG_SHIFT + 1;
  localparam int PDATA_W   = (WIDTH > 32) ? 64 : 32;
  localparam int OUT_W     = byte_bits(WIDTH);
  localparam int CNT_W     = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_SQ_WAIT,
    S_MUL,
    S_MUL_WAIT,
    S_OUT
  } state_t;

  state_t           state;
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] base;
  logic [WIDTH-1:0] expo;
  logic [WIDTH-1:0] acc;
  logic [CNT_W-1:0] bit_cnt;
  logic [WIDTH-1:0] result;

  logic             cfg_write;
  logic             reg_sel;
  logic             in_fire;
  logic             out_free;
  logic [WIDTH-1:0] in_base;
  logic [WIDTH-1:0] in_expo;

  logic             mm_start;
  logic [WIDTH-1:0] mm_b;
  logic             mm_busy;
  logic             mm_done;
  logic [WIDTH-1:0] mm_product;

  // Configuration port.
  assign pready    = 1'b1;
  assign reg_sel   = (paddr[ADDR_W-1:REG_SHIFT] == 1'(REG_MODULUS));
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = reg_sel ? PDATA_W'(modulus) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WIDTH'(1);
    end else if (cfg_write && reg_sel && (pwdata[WIDTH-1:0] != '0)) begin
      modulus <= pwdata[WIDTH-1:0];
    end
  end

  // Stream handshakes.
  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign in_base  = s_tdata[WIDTH-1:0];
  assign in_expo  = s_tdata[2*WIDTH-1:WIDTH];
  assign m_tdata  = OUT_W'(result);

  // The multiplier takes the accumulator as multiplicand; the second operand
  // is either the accumulator (squaring) or the unreduced base.
  assign mm_start = (state == S_SQ) || (state == S_MUL);
  assign mm_b     = (state == S_MUL) ? base : acc;

  mexp_modmul #(.WIDTH(WIDTH)) u_modmul (
    .clk     (clk),
    .rst     (rst),
    .start   (mm_start),
    .a       (acc),
    .b       (mm_b),
    .m       (modulus),
    .busy    (mm_busy),
    .done    (mm_done),
    .product (mm_product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // In S_OUT the valid flag is handled by the load below.
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            base    <= in_base;
            expo    <= in_expo;
            bit_cnt <= CNT_W'(WIDTH - 1);
            if (in_expo == '0) begin
              acc   <= WIDTH'(1);
              state <= S_OUT;
            end else begin
              // 1 mod m is zero only for a modulus of one.
              acc   <= (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
              state <= S_SQ;
            end
          end
        end
        S_SQ: begin
          state <= S_SQ_WAIT;
        end
        S_SQ_WAIT: begin
          if (mm_done) begin
            acc <= mm_product;
            if (expo[WIDTH-1]) begin
              state <= S_MUL;
            end else begin
              expo <= expo << 1;
              if (bit_cnt == '0) begin
                state <= S_OUT;
              end else begin
                bit_cnt <= bit_cnt - 1'b1;
                state   <= S_SQ;
              end
            end
          end
        end
        S_MUL: begin
          state <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (mm_done) begin
            acc  <= mm_product;
            expo <= expo << 1;
            if (bit_cnt == '0) begin
              state <= S_OUT;
            end else begin
              bit_cnt <= bit_cnt - 1'b1;
              state   <= S_SQ;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            result   <= acc;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The running power stays reduced while a product chain is in progress.
  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ_WAIT || state == S_MUL_WAIT) |-> (acc < modulus))
    else $error("accumulator not reduced below the modulus");

  // Every product from the shared multiplier is reduced.
  a_product_reduced: assert property (@(posedge clk) disable iff (rst)
    mm_done |-> (mm_product < modulus))
    else $error("multiplier product not reduced below the modulus");

  // A new item is only taken while the multiplier is free.
  a_ready_idle_unit: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !mm_busy)
    else $error("input ready while the multiplier is busy");

  // A result is loaded only when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && m_tvalid && !m_tready) |=> (state == S_OUT))
    else $error("result left the sequencer while the output was stalled");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for modular_exponentiation: directed and random
// transactions against an in-bench square-and-multiply predictor.
// Depends on mexp_pkg and the modular_exponentiation RTL.
`timescale 1ns / 100ps

module testbench;
  import mexp_pkg::*;

  localparam int WIDTH     = MEXP_WIDTH;
  localparam int DATA_BITS = byte_bits(2*WIDTH);
  localparam int RES_BITS  = byte_bits(WIDTH);
  localparam int ADDR_BITS = (WIDTH > 32) ? 4 : 3;
  localparam int PDATA_BITS = (WIDTH > 32) ? 64 : 32;
  localparam int REG_STRIDE = (WIDTH > 32) ? 8 : 4;

  localparam logic [ADDR_BITS-1:0] MODULUS_ADDR = ADDR_BITS'(REG_STRIDE*REG_MODULUS);
  localparam logic [ADDR_BITS-1:0] SPARE_ADDR   = ADDR_BITS'(REG_STRIDE*(REG_MODULUS+1));
  localparam logic [WIDTH-1:0]     ALL_ONES     = '1;
  localparam int TAIL_CYCLES = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_tvalid = 1'b0;
  wire                   s_tready;
  logic [DATA_BITS-1:0]  s_tdata  = '0;
  wire                   m_tvalid;
  logic                  m_tready = 1'b0;
  wire  [RES_BITS-1:0]   m_tdata;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [ADDR_BITS-1:0]  paddr    = '0;
  logic [PDATA_BITS-1:0] pwdata   = '0;
  wire  [PDATA_BITS-1:0] prdata;
  wire                   pready;

  logic [WIDTH-1:0] pending_powers[$];
  logic [WIDTH-1:0] modulus_shadow = 1;
  int mismatches    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int hold_left     = 0;

  modular_exponentiation #(.WIDTH(WIDTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  // base ** exponent mod modulus; operands stay below the modulus, so every
  // product fits in twice the width.
  function automatic logic [WIDTH-1:0] expected_power(input logic [WIDTH-1:0] base,
                                                      input logic [WIDTH-1:0] exponent,
                                                      input logic [WIDTH-1:0] modulus);
    logic [2*WIDTH-1:0] acc;
    logic [2*WIDTH-1:0] square;
    int i;
    if (exponent == 0) return 1;
    acc    = 1 % modulus;
    square = base % modulus;
    for (i = 0; i < WIDTH; i++) begin
      if (exponent[i]) acc = (acc * square) % modulus;
      square = (square * square) % modulus;
    end
    return acc[WIDTH-1:0];
  endfunction

  function automatic logic [WIDTH-1:0] pick_modulus();
    case ($urandom_range(7))
      0:       return 1;
      1:       return 2;
      2:       return ALL_ONES;
      3:       return $urandom_range(255, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WIDTH-1:0] pick_base();
    case ($urandom_range(7))
      0:       return 0;
      1:       return ALL_ONES;
      2, 3:    return $urandom % modulus_shadow;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WIDTH-1:0] pick_exponent();
    case ($urandom_range(7))
      0:       return 0;
      1:       return ALL_ONES;
      2:       return $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    logic [WIDTH-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_powers.size() == 0) begin
        $error("power_mod: expected none, actual %h", m_tdata[WIDTH-1:0]);
        mismatches++;
      end else begin
        want = pending_powers.pop_front();
        if (m_tdata[WIDTH-1:0] !== want) begin
          $error("power_mod: expected %h, actual %h", want, m_tdata[WIDTH-1:0]);
          mismatches++;
        end
      end
    end
  end

  task automatic write_reg(input logic [ADDR_BITS-1:0] addr, input logic [WIDTH-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= PDATA_BITS'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // Only the modulus exists, and a zero is refused.
    if (addr == MODULUS_ADDR && value != 0) modulus_shadow = value;
  endtask

  task automatic send_power(input logic [WIDTH-1:0] base, input logic [WIDTH-1:0] exponent);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= DATA_BITS'({exponent, base});
    do @(posedge clk); while (!s_tready);
    pending_powers.push_back(expected_power(base, exponent, modulus_shadow));
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_reset_modulus();
    send_power(5, 0);
    send_power(ALL_ONES, 0);
    send_power(7, 3);
    send_power(0, ALL_ONES);
    wait_drain();
  endtask

  task automatic test_register_writes();
    write_reg(MODULUS_ADDR, 7);
    send_power(10, 1);
    send_power(3, 6);
    send_power(100, 0);
    wait_drain();
    // A zero modulus must not take effect.
    write_reg(MODULUS_ADDR, 0);
    send_power(10, 1);
    wait_drain();
    write_reg(SPARE_ADDR, 13);
    send_power(9, 2);
    wait_drain();
  endtask

  task automatic test_extremes();
    write_reg(MODULUS_ADDR, ALL_ONES);
    send_power(ALL_ONES, 1);
    send_power(ALL_ONES - 1, ALL_ONES);
    send_power(0, 5);
    send_power(0, 0);
    send_power(32'h1234_5678, 1);
    wait_drain();
    write_reg(MODULUS_ADDR, 2);
    send_power(3, ALL_ONES);
    send_power(4, 7);
    wait_drain();
    // Largest 32-bit prime: Fermat gives 1 for p-1.
    write_reg(MODULUS_ADDR, 32'd4294967291);
    send_power(2, 32'd4294967290);
    send_power(ALL_ONES, 3);
    send_power(123456789, 32'h8000_0000);
    wait_drain();
  endtask

  task automatic test_output_stall();
    int n;
    write_reg(MODULUS_ADDR, 1000003);
    recv_idle_pct = 0;
    hold_request  = 600;
    for (n = 0; n < 6; n++)
      send_power($urandom, (n < 4) ? 0 : $urandom_range(255, 1));
    wait_drain();
  endtask

  task automatic test_random(input int sender_idle, input int receiver_idle, input int items);
    int n;
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    for (n = 0; n < items; n++) begin
      if (n % 12 == 0) begin
        wait_drain();
        write_reg(MODULUS_ADDR, pick_modulus());
      end
      send_power(pick_base(), pick_exponent());
    end
    wait_drain();
  endtask

  initial begin
    #60000000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    send_idle_pct = 26;
    recv_idle_pct = 58;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_modulus();
    test_register_writes();
    test_extremes();
    test_output_stall();
    test_random(26, 58, 38);
    test_random(58, 26, 38);
    test_random(0, 0, 39);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_powers.size() != 0) begin
      $error("power_mod: %0d results never arrived", pending_powers.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mexp_pkg.sv
sv/mexp_addmod.sv
sv/mexp_modmul.sv
sv/modular_exponentiation.sv
dv/testbench.sv
